>>> rtl/pca_pkg.sv
// Shared types and constants of the palette colour allocator.
// No dependencies.
package pca_pkg;
  localparam int MaxColors   = 256;
  localparam int HashBuckets = 256;
  localparam int IdxW = $clog2(MaxColors);
  localparam int BktW = $clog2(HashBuckets);
  localparam int CntW = IdxW + 1;
  localparam int ModW = 16 + 9 + 16 + 8;

  localparam logic [1:0] RegReduce = 2'd0;
  localparam logic [1:0] RegMul    = 2'd1;
  localparam logic [1:0] RegBucket = 2'd2;
  localparam logic [1:0] RegLimit  = 2'd3;

  localparam logic [1:0] StFound  = 2'd0;
  localparam logic [1:0] StInsert = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MOD, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_INS, S_OUT
  } state_t;

  function automatic logic [7:0] round_channel(input logic [7:0] v, input logic [2:0] lvl);
    logic [8:0] add;
    logic [8:0] mask;
    logic [8:0] x;
    add  = (lvl == 3'd0) ? 9'd0 : (9'd1 << (lvl - 3'd1));
    mask = 9'h1ff << lvl;
    if (lvl == 3'd7) mask = 9'o600;
    x = ({1'b0, v} + add) & mask;
    return (x >= 9'd255) ? 8'd255 : x[7:0];
  endfunction
endpackage

>>> rtl/pca_if.sv
// Valid/ready channel interface carrying a payload word.
// Depends on nothing.
interface pca_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pca_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pca_ram #(parameter int W = 8, parameter int D = 256) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/pca_mod.sv
// Iterative restoring modulo of the hash by the bucket count, one bit a cycle.
// Depends on pca_pkg.
module pca_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pca_pkg::ModW-1:0]      num,
  input  logic [8:0]                    den,
  output logic                          done,
  output logic [pca_pkg::BktW-1:0]      rem
);
  localparam int CW = $clog2(pca_pkg::ModW + 1);
  logic [pca_pkg::ModW-1:0] sh;
  logic [9:0] r;
  logic [CW-1:0] cnt;
  logic busy;
  logic [9:0] t;
  assign t = {r[8:0], sh[pca_pkg::ModW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sh <= num;
        r <= '0;
        cnt <= CW'(pca_pkg::ModW);
      end else if (busy) begin
        sh <= sh << 1;
        r <= (t >= {1'b0, den}) ? t - {1'b0, den} : t;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = r[pca_pkg::BktW-1:0];
endmodule

>>> rtl/palette_color_allocator_core.sv
// Palette colour allocator: top level with sequencer, the two memories and the modulo unit.
// Depends on pca_pkg, pca_if, pca_ram, pca_mod.
//
// Input channel: one word of red, green, blue. Output channel: one word of
// palette index, status and the three rounded channels. Configuration writes
// go through a plain write port; the user must make them only while idle, as
// the block itself does not enforce this. One item at a time. The hash
// modulo shifts one bit a cycle over the 49-bit hash, and each chain entry
// visited goes through the entry memory's registered read port (states S_ENT
// and S_ENTW). With the receiver ready the state returns to idle once the
// word goes out, and the next item is accepted from there. Reset loads the
// default configuration, clears the entry count and, through a valid bit
// per bucket held in flip-flops, every chain head; no clearing pass is needed.
// A finished word is held in the output register until taken; the next item
// is not accepted until then. Palette index is zero when the palette is full.
module palette_color_allocator_core (
  input  logic        clk,
  input  logic        rst,
  pca_if.sink         in_ch,
  pca_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int IW = pca_pkg::IdxW;
  localparam int BW = pca_pkg::BktW;
  localparam int CW = pca_pkg::CntW;

  logic [2:0]  reduce_level;
  logic [15:0] hash_multiplier;
  logic [8:0]  bucket_count;
  logic [8:0]  color_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_level <= 3'd0;
      hash_multiplier <= 16'd2;
      bucket_count <= 9'd256;
      color_limit <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pca_pkg::RegReduce: reduce_level <= cfg_data[2:0];
        pca_pkg::RegMul:    hash_multiplier <= cfg_data;
        pca_pkg::RegBucket: bucket_count <= cfg_data[8:0];
        pca_pkg::RegLimit:  color_limit <= cfg_data[8:0];
      endcase
    end
  end

  pca_pkg::state_t state, state_next;
  logic [7:0] r, g, b;
  logic [24:0] acc1;
  logic [pca_pkg::ModW-1:0] acc2;
  logic [BW-1:0] bkt;
  logic [CW-1:0] entry_count;
  logic [pca_pkg::HashBuckets-1:0] head_valid;
  logic have;
  logic [IW-1:0] cur;
  logic [CW-1:0] steps;
  logic [7:0] o_idx;
  logic [1:0] o_st;
  logic mod_go;

  // head memory holds the index only; head valid kept in flip-flops, link valid kept in entry
  logic        head_we, ent_we;
  logic [BW-1:0] head_addr;
  logic [IW-1:0] ent_addr;
  logic [IW-1:0] head_rd, head_wd;
  logic [24+IW:0] ent_rd, ent_wd;
  logic mod_start, mod_done;
  logic [BW-1:0] mod_rem;
  logic [8:0] den;
  logic [CW-1:0] limit;
  logic [CW-1:0] cur_ext;
  logic match;

  assign den = (bucket_count == 9'd0) ? 9'd1 :
               ({1'b0, bucket_count} > 10'(pca_pkg::HashBuckets)) ?
               9'(pca_pkg::HashBuckets) : bucket_count;
  assign limit = ({1'b0, color_limit} > 10'(pca_pkg::MaxColors)) ?
                 CW'(pca_pkg::MaxColors) : CW'(color_limit);

  pca_ram #(.W(IW), .D(pca_pkg::HashBuckets)) u_head (
    .clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wd), .rdata(head_rd));
  pca_ram #(.W(25 + IW), .D(pca_pkg::MaxColors)) u_ent (
    .clk(clk), .we(ent_we), .addr(ent_addr), .wdata(ent_wd), .rdata(ent_rd));
  pca_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .num(acc2), .den(den),
    .done(mod_done), .rem(mod_rem));

  assign cur_ext = CW'(cur);
  assign match = ent_rd[24+IW:1+IW] == {r, g, b};

  always_comb begin
    state_next = state;
    unique case (state)
      pca_pkg::S_IDLE:  if (in_ch.valid) state_next = pca_pkg::S_MUL1;
      pca_pkg::S_MUL1:  state_next = pca_pkg::S_MUL2;
      pca_pkg::S_MUL2:  state_next = pca_pkg::S_MOD;
      pca_pkg::S_MOD:   if (mod_done) state_next = pca_pkg::S_HEAD;
      pca_pkg::S_HEAD:  state_next = pca_pkg::S_HEADW;
      pca_pkg::S_HEADW: state_next = pca_pkg::S_ENT;
      pca_pkg::S_ENT:
        if (have && cur_ext < entry_count && steps < CW'(pca_pkg::MaxColors))
          state_next = pca_pkg::S_ENTW;
        else state_next = pca_pkg::S_INS;
      pca_pkg::S_ENTW:  state_next = match ? pca_pkg::S_OUT : pca_pkg::S_ENT;
      pca_pkg::S_INS:   state_next = pca_pkg::S_OUT;
      pca_pkg::S_OUT:   if (out_ch.ready) state_next = pca_pkg::S_IDLE;
      default:          state_next = pca_pkg::S_IDLE;
    endcase
  end

  logic do_ins;
  assign do_ins = (state == pca_pkg::S_INS) && (entry_count < limit);

  always_comb begin
    in_ch.ready = state == pca_pkg::S_IDLE;
    out_ch.valid = state == pca_pkg::S_OUT;
    out_ch.data = {o_idx, o_st, r, g, b};
    // divider starts once acc2 holds the finished hash
    mod_start = mod_go;
    head_addr = bkt;
    head_we = do_ins;
    head_wd = entry_count[IW-1:0];
    ent_addr = (state == pca_pkg::S_INS) ? entry_count[IW-1:0] : cur;
    ent_we = do_ins;
    ent_wd = {r, g, b, head_valid[bkt], head_rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pca_pkg::S_IDLE;
      entry_count <= '0;
      head_valid <= '0;
      mod_go <= 1'b0;
    end else begin
      state <= state_next;
      mod_go <= state == pca_pkg::S_MUL2;
      if (do_ins) begin
        entry_count <= entry_count + 1'b1;
        head_valid[bkt] <= 1'b1;
      end
    end
    unique case (state)
      pca_pkg::S_IDLE: begin
        r <= pca_pkg::round_channel(in_ch.data[23:16], reduce_level);
        g <= pca_pkg::round_channel(in_ch.data[15:8], reduce_level);
        b <= pca_pkg::round_channel(in_ch.data[7:0], reduce_level);
      end
      pca_pkg::S_MUL1: acc1 <= 25'({9'd0, g}) + 25'(r) * 25'(hash_multiplier);
      pca_pkg::S_MUL2: acc2 <= pca_pkg::ModW'(b) +
                              pca_pkg::ModW'(acc1) * pca_pkg::ModW'(hash_multiplier);
      pca_pkg::S_MOD:  if (mod_done) bkt <= mod_rem;
      pca_pkg::S_HEADW: begin
        have <= head_valid[bkt];
        cur <= head_rd;
        steps <= '0;
        o_idx <= 8'd0;
        o_st <= pca_pkg::StFull;
      end
      pca_pkg::S_ENTW: begin
        if (match) begin
          o_idx <= 8'(cur);
          o_st <= pca_pkg::StFound;
        end else begin
          have <= ent_rd[IW];
          cur <= ent_rd[IW-1:0];
          steps <= steps + 1'b1;
        end
      end
      pca_pkg::S_INS: if (do_ins) begin
        o_idx <= 8'(entry_count);
        o_st <= pca_pkg::StInsert;
      end
      default: ;
    endcase
  end
endmodule
